@@ sv/dda_pkg.sv @@
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared widths, register indexes and the control and status bundles.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TILE_SIZE  = 64;
  localparam int COORD_BITS = 12;

  localparam int COLOR_W   = 16;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = $clog2(TILE_SIZE);

  localparam int NUM_W  = COORD_BITS + FRAC_BITS;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int INC_W  = FRAC_BITS + 2;
  localparam int POS_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  localparam logic [CFG_W-1:0] FRAME_RESET = CFG_W'(TILE_SIZE);
  localparam logic [CFG_W-1:0] TILE_LIMIT  = CFG_W'(TILE_SIZE);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic load;
    logic div_run;
    logic setup;
    logic step;
    logic flush;
  } dda_cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
    logic hit;
    logic pend_valid;
    logic out_free;
  } dda_sts_t;

endpackage

@@ sv/dda_cmd_if.sv @@
// ----------------------------------------------------------------------------
// Line command channel
// Carries one line command per transfer: two endpoints and a color.
// ----------------------------------------------------------------------------
interface dda_cmd_if;

  logic                          valid;
  logic                          ready;
  dda_pkg::coord_t               start_x;
  dda_pkg::coord_t               start_y;
  dda_pkg::coord_t               end_x;
  dda_pkg::coord_t               end_y;
  logic [dda_pkg::COLOR_W-1:0]   color;

  modport source (output valid, start_x, start_y, end_x, end_y, color, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, color, output ready);

endinterface

@@ sv/dda_pix_if.sv @@
// ----------------------------------------------------------------------------
// Pixel channel
// Carries one plotted pixel or one empty-line marker per transfer.
// ----------------------------------------------------------------------------
interface dda_pix_if;

  logic                          valid;
  logic                          ready;
  logic [dda_pkg::PIX_W-1:0]     pixel_x;
  logic [dda_pkg::PIX_W-1:0]     pixel_y;
  logic [dda_pkg::COLOR_W-1:0]   pixel_color;
  logic                          visible;
  logic                          last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, visible, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, visible, last, output ready);

endinterface

@@ sv/dda_div.sv @@
// ----------------------------------------------------------------------------
// DDA increment divider
// Two restoring division lanes share one divisor; one quotient bit per cycle while run_i.
// ----------------------------------------------------------------------------
module dda_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           run_i,
  input  logic [dda_pkg::NUM_W-1:0]      num_x_i,
  input  logic [dda_pkg::NUM_W-1:0]      num_y_i,
  input  logic [dda_pkg::COORD_BITS-1:0] divisor_i,
  output logic [dda_pkg::NUM_W-1:0]      quot_x_o,
  output logic [dda_pkg::NUM_W-1:0]      quot_y_o,
  output logic                           done_o
);
  import dda_pkg::*;

  logic [DCNT_W-1:0]     cnt_q, cnt_d;
  logic [COORD_BITS-1:0] divisor_q;
  logic [COORD_BITS-1:0] rem_q [2];
  logic [COORD_BITS-1:0] rem_d [2];
  logic [NUM_W-1:0]      num_q [2];
  logic [NUM_W-1:0]      num_d [2];
  logic [COORD_BITS:0]   trial [2];
  logic [COORD_BITS:0]   diff  [2];

  assign done_o = (cnt_q == DCNT_W'(NUM_W));

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i] = {rem_q[i], num_q[i][NUM_W-1]};
      diff[i]  = trial[i] - {1'b0, divisor_q};
      if (trial[i] >= {1'b0, divisor_q}) begin
        rem_d[i] = diff[i][COORD_BITS-1:0];
        num_d[i] = {num_q[i][NUM_W-2:0], 1'b1};
      end else begin
        rem_d[i] = trial[i][COORD_BITS-1:0];
        num_d[i] = {num_q[i][NUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = '0;
    end else if (run_i && !done_o) begin
      cnt_d = cnt_q + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= DCNT_W'(NUM_W);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= divisor_i;
      rem_q[0]  <= '0;
      rem_q[1]  <= '0;
      num_q[0]  <= num_x_i;
      num_q[1]  <= num_y_i;
    end else if (run_i && !done_o) begin
      rem_q[0] <= rem_d[0];
      rem_q[1] <= rem_d[1];
      num_q[0] <= num_d[0];
      num_q[1] <= num_d[1];
    end
  end

  assign quot_x_o = num_q[0];
  assign quot_y_o = num_q[1];

endmodule

@@ sv/dda_dpath.sv @@
// ----------------------------------------------------------------------------
// DDA datapath
// Frame registers, step setup, position accumulators, clipping, the pending
// pixel that resolves the last flag, and the output register.
// ----------------------------------------------------------------------------
module dda_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dda_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dda_pkg::CFG_W-1:0]       cfg_data_i,
  input  dda_pkg::coord_t                 start_x_i,
  input  dda_pkg::coord_t                 start_y_i,
  input  dda_pkg::coord_t                 end_x_i,
  input  dda_pkg::coord_t                 end_y_i,
  input  logic [dda_pkg::COLOR_W-1:0]     color_i,
  input  dda_pkg::dda_cmd_t               cmd_i,
  output dda_pkg::dda_sts_t               sts_o,
  output logic                            pix_valid_o,
  input  logic                            pix_ready_i,
  output logic [dda_pkg::PIX_W-1:0]       pixel_x_o,
  output logic [dda_pkg::PIX_W-1:0]       pixel_y_o,
  output logic [dda_pkg::COLOR_W-1:0]     pixel_color_o,
  output logic                            visible_o,
  output logic                            last_o
);
  import dda_pkg::*;

  logic [CFG_W-1:0] fw_q, fh_q;
  logic [CFG_W-1:0] w_eff, h_eff;

  logic signed [COORD_BITS:0] dx_w, dy_w;
  logic [COORD_BITS:0]        adx_w, ady_w;
  logic [COORD_BITS-1:0]      ax_w, ay_w, l_w, divisor_w;
  logic [NUM_W-1:0]           quot_x, quot_y;
  logic                       div_done;

  logic                    sx_q, sy_q;
  logic [COORD_BITS-1:0]   l_q, k_q;
  logic [COLOR_W-1:0]      color_q;
  logic signed [INC_W-1:0] incx_q, incy_q, qx_s, qy_s;
  logic signed [POS_W-1:0] px_q, py_q;

  logic signed [COORD_BITS:0] cx_w, cy_w;
  logic                       hit_w, walk_done, out_free;

  logic             pend_valid_q;
  logic [PIX_W-1:0] pend_x_q, pend_y_q;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_RESET;
      fh_q <= FRAME_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i;
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff = (fw_q > TILE_LIMIT) ? TILE_LIMIT : fw_q;
  assign h_eff = (fh_q > TILE_LIMIT) ? TILE_LIMIT : fh_q;

  assign dx_w      = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
  assign dy_w      = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
  assign adx_w     = dx_w[COORD_BITS] ? -dx_w : dx_w;
  assign ady_w     = dy_w[COORD_BITS] ? -dy_w : dy_w;
  assign ax_w      = adx_w[COORD_BITS-1:0];
  assign ay_w      = ady_w[COORD_BITS-1:0];
  assign l_w       = (ax_w > ay_w) ? ax_w : ay_w;
  assign divisor_w = (l_w == '0) ? COORD_BITS'(1) : l_w;

  dda_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.load),
    .run_i     (cmd_i.div_run),
    .num_x_i   ({ax_w, {FRAC_BITS{1'b0}}}),
    .num_y_i   ({ay_w, {FRAC_BITS{1'b0}}}),
    .divisor_i (divisor_w),
    .quot_x_o  (quot_x),
    .quot_y_o  (quot_y),
    .done_o    (div_done)
  );

  assign qx_s = $signed({1'b0, quot_x[QUO_W-1:0]});
  assign qy_s = $signed({1'b0, quot_y[QUO_W-1:0]});

  assign cx_w = px_q[POS_W-1:FRAC_BITS];
  assign cy_w = py_q[POS_W-1:FRAC_BITS];

  assign hit_w = !cx_w[COORD_BITS] && !cy_w[COORD_BITS]
              && (cx_w < $signed({{(COORD_BITS+1-CFG_W){1'b0}}, w_eff}))
              && (cy_w < $signed({{(COORD_BITS+1-CFG_W){1'b0}}, h_eff}));

  assign walk_done = (k_q == l_q);
  assign out_free  = !out_valid_q || pix_ready_i;

  assign sts_o.div_done   = div_done;
  assign sts_o.walk_done  = walk_done;
  assign sts_o.hit        = hit_w;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      l_q <= '0;
    end else if (cmd_i.load) begin
      k_q <= '0;
      l_q <= l_w;
    end else if (cmd_i.step) begin
      k_q <= k_q + COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q    <= dx_w[COORD_BITS];
      sy_q    <= dy_w[COORD_BITS];
      color_q <= color_i;
      px_q    <= {{(POS_W-FRAC_BITS-COORD_BITS){start_x_i[COORD_BITS-1]}}, start_x_i,
                  {FRAC_BITS{1'b0}}};
      py_q    <= {{(POS_W-FRAC_BITS-COORD_BITS){start_y_i[COORD_BITS-1]}}, start_y_i,
                  {FRAC_BITS{1'b0}}};
    end else if (cmd_i.step) begin
      px_q <= px_q + {{(POS_W-INC_W){incx_q[INC_W-1]}}, incx_q};
      py_q <= py_q + {{(POS_W-INC_W){incy_q[INC_W-1]}}, incy_q};
    end
    if (cmd_i.setup) begin
      incx_q <= sx_q ? -qx_s : qx_s;
      incy_q <= sy_q ? -qy_s : qy_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.load || cmd_i.flush) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.step && hit_w) begin
      pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && hit_w) begin
      pend_x_q <= cx_w[PIX_W-1:0];
      pend_y_q <= cy_w[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.step && hit_w && pend_valid_q) || cmd_i.flush) begin
      out_valid_q <= 1'b1;
    end else if (pix_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && hit_w && pend_valid_q) begin
      pixel_x_o     <= pend_x_q;
      pixel_y_o     <= pend_y_q;
      pixel_color_o <= color_q;
      visible_o     <= 1'b1;
      last_o        <= 1'b0;
    end else if (cmd_i.flush) begin
      pixel_x_o     <= pend_valid_q ? pend_x_q : '0;
      pixel_y_o     <= pend_valid_q ? pend_y_q : '0;
      pixel_color_o <= color_q;
      visible_o     <= pend_valid_q;
      last_o        <= 1'b1;
    end
  end

  assign pix_valid_o = out_valid_q;

  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !visible_o) |-> last_o)
    else $error("Empty-line marker presented without last set.");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= l_q)
    else $error("Step counter ran past the step count.");

endmodule

@@ sv/dda_ctrl.sv @@
// ----------------------------------------------------------------------------
// DDA controller
// Sequences command load, increment division, the walk and the final flush.
// ----------------------------------------------------------------------------
module dda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dda_pkg::dda_sts_t sts_i,
  output dda_pkg::dda_cmd_t cmd_o
);
  import dda_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.setup = 1'b1;
          state_d     = S_WALK;
        end else begin
          cmd_o.div_run = 1'b1;
        end
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          state_d = S_FLUSH;
        end else if (!(sts_i.hit && sts_i.pend_valid && !sts_i.out_free)) begin
          cmd_o.step = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !sts_i.pend_valid)
    else $error("A pending pixel survived the end of a line.");

  a_load_restarts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_DIV) && !sts_i.div_done)
    else $error("Divider did not restart on a new line command.");

endmodule

@@ sv/dda_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Fixed-point DDA line drawing with clipping to the configured frame.
// ----------------------------------------------------------------------------
// A line command with step count l = max(|dx|, |dy|) passes through the
// increment division and then the walk: the two increments come from a
// restoring divider that produces one quotient bit per cycle, and the
// walk then visits one position per cycle while the pixel sink does not
// stall. A new command is taken only once the previous one has handed its
// final result to the output register. Each pixel is held back by one
// visible position so that the last flag can be set on it; an invisible
// line yields a single marker with visible low and last high.
module dda_line_rasterizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dda_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dda_pkg::CFG_W-1:0]     cfg_data_i,
  dda_cmd_if.sink                       cmd_i,
  dda_pix_if.source                     pix_o
);
  import dda_pkg::*;

  dda_cmd_t cmd;
  dda_sts_t sts;
  logic     in_ready;

  dda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign cmd_i.ready = in_ready;

  dda_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start_x_i     (cmd_i.start_x),
    .start_y_i     (cmd_i.start_y),
    .end_x_i       (cmd_i.end_x),
    .end_y_i       (cmd_i.end_y),
    .color_i       (cmd_i.color),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pix_valid_o   (pix_o.valid),
    .pix_ready_i   (pix_o.ready),
    .pixel_x_o     (pix_o.pixel_x),
    .pixel_y_o     (pix_o.pixel_y),
    .pixel_color_o (pix_o.pixel_color),
    .visible_o     (pix_o.visible),
    .last_o        (pix_o.last)
  );

endmodule
